@@ sv/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared constants, register codes and types of the bilinear ARGB sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int TEX_DIM    = 128;
  localparam int DIM_W      = 8;
  localparam int CRD_W      = 7;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = CRD_W + FRAC_W;
  localparam int TEX_WORDS  = 16384;
  localparam int ADDR_W     = 14;
  localparam int MAX_SPAN   = 16;
  localparam int LEN_W      = 5;
  localparam int STEP_W     = 24;
  localparam int ORG_W      = 32;
  localparam int PIX_W      = 32;
  localparam int Q_W        = 28;
  localparam int DIV_BITS   = 7;
  localparam int DIV_STAGES = Q_W / DIV_BITS;
  localparam int NSTG       = 11;
  localparam int NTAP       = 4;

  typedef enum logic [2:0] {
    REG_TEX_WIDTH  = 3'd0,
    REG_TEX_HEIGHT = 3'd1,
    REG_ROW_PITCH  = 3'd2,
    REG_ORIGIN_X   = 3'd3,
    REG_ORIGIN_Y   = 3'd4,
    REG_STEP_X     = 3'd5,
    REG_STEP_Y     = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

  typedef logic [NSTG-1:0] stg_vec_t;

  typedef struct packed {
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_req_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(TEX_DIM)) ? DIM_W'(TEX_DIM) : v;
  endfunction

endpackage

@@ sv/bts_axis.sv @@
// ----------------------------------------------------------------------------
// Sampler axis unit
// Computes one clamped unsigned 7.16 sample coordinate through a product stage,
// a pipelined span divider and a sum and clamp stage.
// ----------------------------------------------------------------------------
module bts_axis (
  input  logic                           clk,
  input  bts_pkg::stg_vec_t              stg_en,
  input  logic [7:0]                     lpos,
  input  logic [3:0]                     idx,
  input  logic [bts_pkg::LEN_W-1:0]      len,
  input  logic [bts_pkg::STEP_W-1:0]     step,
  input  logic signed [bts_pkg::ORG_W-1:0] origin,
  input  logic [bts_pkg::DIM_W-1:0]      dim,
  output logic [bts_pkg::POS_W-1:0]      cpos_r
);

  typedef struct packed {
    logic [bts_pkg::LEN_W-1:0] rem;
    logic [bts_pkg::Q_W-1:0]   qn;
  } div_t;

  function automatic div_t div_step(input div_t s, input logic [bts_pkg::LEN_W-1:0] d,
                                    input int k);
    div_t r;
    logic [bts_pkg::LEN_W:0] t;
    int p;
    r = s;
    for (int i = 0; i < bts_pkg::DIV_BITS; i++) begin
      p = bts_pkg::Q_W - 1 - bts_pkg::DIV_BITS * k - i;
      t = {r.rem, r.qn[p]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        r.qn[p] = 1'b1;
      end else begin
        r.qn[p] = 1'b0;
      end
      r.rem = t[bts_pkg::LEN_W-1:0];
    end
    return r;
  endfunction

  localparam int NDS = bts_pkg::DIV_STAGES;

  logic [bts_pkg::LEN_W-1:0] len_c;
  logic [bts_pkg::Q_W:0]     prod;
  logic [31:0]               base;

  div_t                      div_r  [NDS+1];
  logic [bts_pkg::LEN_W-1:0] len_r  [NDS+1];
  logic                      zero_r [NDS+1];
  logic [31:0]               base_r [NDS+1];

  assign len_c = (len > bts_pkg::LEN_W'(bts_pkg::MAX_SPAN)) ?
                 bts_pkg::LEN_W'(bts_pkg::MAX_SPAN) : len;
  assign prod  = (bts_pkg::Q_W+1)'({idx, 1'b1}) * (bts_pkg::Q_W+1)'(step);
  assign base  = 32'(lpos) * 32'(step);

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      div_r[0].rem <= '0;
      div_r[0].qn  <= prod[bts_pkg::Q_W:1];
      len_r[0]     <= len_c;
      zero_r[0]    <= (step == '0) || (len == '0);
      base_r[0]    <= base;
    end
  end

  for (genvar s = 1; s <= NDS; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (stg_en[s+1]) begin
        div_r[s]  <= div_step(div_r[s-1], len_r[s-1], s - 1);
        len_r[s]  <= len_r[s-1];
        zero_r[s] <= zero_r[s-1];
        base_r[s] <= base_r[s-1];
      end
    end
  end

  logic signed [34:0]          off_s;
  logic signed [34:0]          sum_s;
  logic [bts_pkg::DIM_W-1:0]   dim_m1;
  logic [bts_pkg::POS_W-1:0]   hi;
  logic [bts_pkg::POS_W-1:0]   cpos_nxt;

  always_comb begin
    off_s  = zero_r[NDS] ? 35'sd0 :
             ($signed({7'b0, div_r[NDS].qn}) - 35'sd32768);
    sum_s  = $signed({{3{origin[bts_pkg::ORG_W-1]}}, origin}) +
             $signed({3'b0, base_r[NDS]}) + off_s;
    dim_m1 = dim - 8'd1;
    hi     = {dim_m1[bts_pkg::CRD_W-1:0], {bts_pkg::FRAC_W{1'b0}}};
    if (sum_s[34]) begin
      cpos_nxt = '0;
    end else if (sum_s > $signed({12'b0, hi})) begin
      cpos_nxt = hi;
    end else begin
      cpos_nxt = sum_s[bts_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[NDS+2]) begin
      cpos_r <= cpos_nxt;
    end
  end

endmodule

@@ sv/bts_store.sv @@
// ----------------------------------------------------------------------------
// Sampler texture store
// Four replicated texel memories, written together, each giving one
// registered texel of the 2x2 footprint per cycle while rd_en is set.
// ----------------------------------------------------------------------------
module bts_store (
  input  logic                         clk,
  input  bts_pkg::wr_req_t             wr,
  input  logic                         rd_en,
  input  logic [bts_pkg::ADDR_W-1:0]   raddr [bts_pkg::NTAP],
  output logic [bts_pkg::PIX_W-1:0]    rdata [bts_pkg::NTAP]
);

  for (genvar b = 0; b < bts_pkg::NTAP; b++) begin : g_bank
    logic [bts_pkg::PIX_W-1:0] mem [bts_pkg::TEX_WORDS];
    always_ff @(posedge clk) begin
      if (wr.wr) begin
        mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
        rdata[b] <= mem[raddr[b]];
      end
    end
  end

endmodule

@@ sv/bts_filter.sv @@
// ----------------------------------------------------------------------------
// Sampler bilinear filter
// Horizontal then vertical interpolation of each ARGB channel with
// round half up, in two register stages.
// ----------------------------------------------------------------------------
module bts_filter (
  input  logic                          clk,
  input  bts_pkg::stg_vec_t             stg_en,
  input  logic [bts_pkg::PIX_W-1:0]     texel [bts_pkg::NTAP],
  input  logic [bts_pkg::FRAC_W-1:0]    fx,
  input  logic [bts_pkg::FRAC_W-1:0]    fy,
  input  logic                          empty,
  output logic [bts_pkg::PIX_W-1:0]     pixel_r
);

  localparam int HW = 25;
  localparam int AW = 41;

  logic [bts_pkg::FRAC_W:0]   gx;
  logic [HW-1:0]              top_nxt [4];
  logic [HW-1:0]              bot_nxt [4];
  logic [HW-1:0]              top_r   [4];
  logic [HW-1:0]              bot_r   [4];
  logic [bts_pkg::FRAC_W-1:0] fy_r;
  logic [bts_pkg::FRAC_W:0]   gy;
  logic [AW-1:0]              acc     [4];
  logic [bts_pkg::PIX_W-1:0]  pixel_nxt;

  always_comb begin
    gx = 17'h10000 - 17'(fx);
    for (int c = 0; c < 4; c++) begin
      top_nxt[c] = HW'(texel[0][8*c +: 8]) * HW'(gx) + HW'(texel[1][8*c +: 8]) * HW'(fx);
      bot_nxt[c] = HW'(texel[2][8*c +: 8]) * HW'(gx) + HW'(texel[3][8*c +: 8]) * HW'(fx);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[9]) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      fy_r  <= fy;
    end
  end

  always_comb begin
    gy = 17'h10000 - 17'(fy_r);
    pixel_nxt = '0;
    for (int c = 0; c < 4; c++) begin
      acc[c] = AW'(top_r[c]) * AW'(gy) + AW'(bot_r[c]) * AW'(fy_r) + AW'(32'h8000_0000);
      pixel_nxt[8*c +: 8] = (acc[c][AW-1:32] > 9'd255) ? 8'hFF : acc[c][39:32];
    end
    if (empty) begin
      pixel_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[10]) begin
      pixel_r <= pixel_nxt;
    end
  end

endmodule

@@ sv/bilinear_argb_texture_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// Bilinear ARGB texture sampler
// Eleven-stage pipeline: input register, span product, four divider stages,
// position clamp, address generation, texel read, and two filter stages.
// One beat is accepted per cycle unless a low out_ready stalls the pipeline.
// A write beat stores its texel when it reaches the read stage, in order.
// Synchronous reset clears the stage valid bits and loads the configuration
// registers with their reset values; the store is not cleared.
// ----------------------------------------------------------------------------
module bilinear_argb_texture_sampler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [13:0]                   in_texel_addr,
  input  logic [31:0]                   in_texel_data,
  input  logic [7:0]                    in_logical_row,
  input  logic [7:0]                    in_logical_column,
  input  logic [3:0]                    in_span_row,
  input  logic [4:0]                    in_row_span_length,
  input  logic [3:0]                    in_span_column,
  input  logic [4:0]                    in_column_span_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_pixel_argb
);

  localparam int NS = bts_pkg::NSTG;

  logic [7:0]         tex_width_r, tex_height_r, row_pitch_r;
  logic signed [31:0] origin_x_r, origin_y_r;
  logic [23:0]        step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= '0;
      tex_height_r <= '0;
      row_pitch_r  <= '0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      step_x_r     <= 24'h010000;
      step_y_r     <= 24'h010000;
    end else if (cfg_wr_en) begin
      unique case (bts_pkg::cfg_reg_t'(cfg_index))
        bts_pkg::REG_TEX_WIDTH:  tex_width_r  <= cfg_data[7:0];
        bts_pkg::REG_TEX_HEIGHT: tex_height_r <= cfg_data[7:0];
        bts_pkg::REG_ROW_PITCH:  row_pitch_r  <= cfg_data[7:0];
        bts_pkg::REG_ORIGIN_X:   origin_x_r   <= cfg_data;
        bts_pkg::REG_ORIGIN_Y:   origin_y_r   <= cfg_data;
        bts_pkg::REG_STEP_X:     step_x_r     <= cfg_data[23:0];
        bts_pkg::REG_STEP_Y:     step_y_r     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic [7:0] w_sat, h_sat, pitch_sat;
  logic       empty;

  assign w_sat     = bts_pkg::sat_dim(tex_width_r);
  assign h_sat     = bts_pkg::sat_dim(tex_height_r);
  assign pitch_sat = bts_pkg::sat_dim(row_pitch_r);
  assign empty     = (w_sat == '0) || (h_sat == '0) || (pitch_sat == '0);

  logic [NS-1:0]     vld_r;
  logic              typ_r [NS-1];
  bts_pkg::stg_vec_t rdy;

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NS - 1; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (rdy[NS-1]) begin
        vld_r[NS-1] <= vld_r[NS-2] && (typ_r[NS-2] == bts_pkg::REQ_SAMPLE);
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NS-1];

  logic [7:0]  lrow_r, lcol_r;
  logic [3:0]  srow_r, scol_r;
  logic [4:0]  rlen_r, clen_r;
  logic [13:0] waddr_r [8];
  logic [31:0] wdata_r [8];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      typ_r[0]   <= in_req_type;
      waddr_r[0] <= in_texel_addr;
      wdata_r[0] <= in_texel_data;
      lrow_r     <= in_logical_row;
      lcol_r     <= in_logical_column;
      srow_r     <= in_span_row;
      rlen_r     <= in_row_span_length;
      scol_r     <= in_span_column;
      clen_r     <= in_column_span_length;
    end
  end

  for (genvar k = 1; k < NS - 1; k++) begin : g_typ
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        typ_r[k] <= typ_r[k-1];
      end
    end
  end

  for (genvar k = 1; k < 8; k++) begin : g_wr
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        waddr_r[k] <= waddr_r[k-1];
        wdata_r[k] <= wdata_r[k-1];
      end
    end
  end

  logic [bts_pkg::POS_W-1:0] cx_r, cy_r;

  bts_axis u_axis_x (
    .clk    (clk),
    .stg_en (rdy),
    .lpos   (lcol_r),
    .idx    (scol_r),
    .len    (clen_r),
    .step   (step_x_r),
    .origin (origin_x_r),
    .dim    (w_sat),
    .cpos_r (cx_r)
  );

  bts_axis u_axis_y (
    .clk    (clk),
    .stg_en (rdy),
    .lpos   (lrow_r),
    .idx    (srow_r),
    .len    (rlen_r),
    .step   (step_y_r),
    .origin (origin_y_r),
    .dim    (h_sat),
    .cpos_r (cy_r)
  );

  logic [6:0]  x0, y0, x1, y1;
  logic [6:0]  wm1, hm1;
  logic [7:0]  wm1_f, hm1_f;
  logic [14:0] row0, row1;
  logic [13:0] addr_nxt [4];
  logic [13:0] addr_r   [4];
  logic [15:0] fx7_r, fy7_r, fx8_r, fy8_r;

  always_comb begin
    wm1_f = w_sat - 8'd1;
    hm1_f = h_sat - 8'd1;
    wm1   = wm1_f[6:0];
    hm1   = hm1_f[6:0];
    x0    = cx_r[22:16];
    y0    = cy_r[22:16];
    x1    = (x0 == wm1) ? x0 : x0 + 7'd1;
    y1    = (y0 == hm1) ? y0 : y0 + 7'd1;
    row0  = 15'(y0) * 15'(pitch_sat);
    row1  = 15'(y1) * 15'(pitch_sat);
    addr_nxt[0] = 14'(row0 + 15'(x0));
    addr_nxt[1] = 14'(row0 + 15'(x1));
    addr_nxt[2] = 14'(row1 + 15'(x0));
    addr_nxt[3] = 14'(row1 + 15'(x1));
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      addr_r <= addr_nxt;
      fx7_r  <= cx_r[15:0];
      fy7_r  <= cy_r[15:0];
    end
    if (rdy[8]) begin
      fx8_r <= fx7_r;
      fy8_r <= fy7_r;
    end
  end

  bts_pkg::wr_req_t st_wr;
  logic [31:0]      texel [4];

  assign st_wr.wr   = rdy[8] && vld_r[7] && (typ_r[7] == bts_pkg::REQ_WRITE);
  assign st_wr.addr = waddr_r[7];
  assign st_wr.data = wdata_r[7];

  bts_store u_store (
    .clk   (clk),
    .wr    (st_wr),
    .rd_en (rdy[8]),
    .raddr (addr_r),
    .rdata (texel)
  );

  bts_filter u_filter (
    .clk     (clk),
    .stg_en  (rdy),
    .texel   (texel),
    .fx      (fx8_r),
    .fy      (fy8_r),
    .empty   (empty),
    .pixel_r (out_pixel_argb)
  );

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy[NS-1] && !(vld_r[NS-2] && (typ_r[NS-2] == bts_pkg::REQ_SAMPLE))) |=> !out_valid)
    else $error("write beat produced a result beat");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[8] && !rdy[8]) |=> vld_r[8])
    else $error("stalled read stage lost its beat");

  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ready)
    else $error("input stalled with an empty input stage");

endmodule
